// File: src/ppt_pkg.sv
// Shared types and constants of the projective point transform.
package ppt_pkg;

    localparam int COEF_W   = 32;
    localparam int NUM_REGS = 8;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_W    = 64;

    // Exact row sum: three 64-bit products plus the shifted offset.
    localparam int SUM_W = 66;
    // Magnitude of a row sum.
    localparam int MAG_W = SUM_W - 1;
    // Divider datapath: the scaled dividend and the divisor shifted up by the quotient width.
    localparam int Q_W   = 32;
    localparam int DIV_W = MAG_W + Q_W;

    localparam logic [Q_W-1:0] S32_MAX = 32'h7FFF_FFFF;
    localparam logic [Q_W-1:0] S32_MIN = 32'h8000_0000;

    localparam logic [CFG_IDX_W-1:0] REG_ROW0_COLS01 = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_ROW0_COLS23 = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_ROW1_COLS01 = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_ROW1_COLS23 = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_ROW2_COLS01 = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_ROW2_COLS23 = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_ROW3_COLS01 = 3'd6;
    localparam logic [CFG_IDX_W-1:0] REG_ROW3_COLS23 = 3'd7;

    typedef logic signed [COEF_W-1:0] t_coef;
    typedef logic signed [SUM_W-1:0]  t_sum;

    // One word in flight through the divider steps.
    typedef struct packed {
        logic             valid;
        logic [DIV_W-1:0] rem;
        logic [MAG_W-1:0] m;
        logic [Q_W-1:0]   q;
        logic             neg;
        logic             n_neg;
        logic             n_zero;
        logic             d_zero;
        logic             sat;
    } t_div_lane;

endpackage

// File: src/point_projective_transform.sv
// A word passes the input register, the row MAC stages and the divider stages in turn.
// Throughput: one word per cycle; start is never refused and busy stays low.
// The divider resolves one quotient bit per pipeline stage.
// The receiver cannot stall, so results leave on the o_done strobe in acceptance order.
// Reset (synchronous, active low) empties the pipeline and loads the identity matrix.
module point_projective_transform #(
    parameter int FRAC_BITS = 16
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    // Configuration write port.
    input  logic                            i_cfg_we,
    input  logic [ppt_pkg::CFG_IDX_W-1:0]   i_cfg_idx,
    input  logic [ppt_pkg::CFG_W-1:0]       i_cfg_data,
    // Input words.
    input  logic                            start,
    output logic                            busy,
    input  logic signed [31:0]              i_in_x,
    input  logic signed [31:0]              i_in_y,
    input  logic signed [31:0]              i_in_z,
    // Result words.
    output logic                            o_done,
    output logic signed [31:0]              o_out_x,
    output logic signed [31:0]              o_out_y,
    output logic signed [31:0]              o_out_z,
    output logic                            o_w_zero_fault
);

    // Fixed-point one, placed in the low or high entry of a register.
    localparam logic [ppt_pkg::CFG_W-1:0] ONE_LO = ppt_pkg::CFG_W'(1) << FRAC_BITS;
    localparam logic [ppt_pkg::CFG_W-1:0] ONE_HI = ONE_LO << ppt_pkg::COEF_W;

    // Matrix registers, two entries per register.
    logic [ppt_pkg::CFG_W-1:0] r_cfg [ppt_pkg::NUM_REGS];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg[ppt_pkg::REG_ROW0_COLS01] <= ONE_LO;
            r_cfg[ppt_pkg::REG_ROW0_COLS23] <= '0;
            r_cfg[ppt_pkg::REG_ROW1_COLS01] <= ONE_HI;
            r_cfg[ppt_pkg::REG_ROW1_COLS23] <= '0;
            r_cfg[ppt_pkg::REG_ROW2_COLS01] <= '0;
            r_cfg[ppt_pkg::REG_ROW2_COLS23] <= ONE_LO;
            r_cfg[ppt_pkg::REG_ROW3_COLS01] <= '0;
            r_cfg[ppt_pkg::REG_ROW3_COLS23] <= ONE_HI;
        end else if (i_cfg_we) begin
            r_cfg[i_cfg_idx] <= i_cfg_data;
        end
    end

    // The pipeline never holds a word back, so every start is taken.
    assign busy = 1'b0;

    // Input register stage.
    logic           r_in_valid;
    ppt_pkg::t_coef r_x, r_y, r_z;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else begin
            r_in_valid <= start && !busy;
        end
    end

    always_ff @(posedge i_clk) begin
        r_x <= i_in_x;
        r_y <= i_in_y;
        r_z <= i_in_z;
    end

    // Four row sums in parallel. Row r takes registers 2r and 2r+1, read straight from the
    // registers. Change the matrix only while the pipeline is empty; this is not enforced.
    logic          sum_valid [4];
    ppt_pkg::t_sum row_sum   [4];

    for (genvar r = 0; r < 4; r++) begin : g_row
        ppt_row_mac #(
            .FRAC_BITS (FRAC_BITS)
        ) u_mac (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_valid (r_in_valid),
            .i_x     (r_x),
            .i_y     (r_y),
            .i_z     (r_z),
            .i_c0    ($signed(r_cfg[2*r][31:0])),
            .i_c1    ($signed(r_cfg[2*r][63:32])),
            .i_c2    ($signed(r_cfg[2*r+1][31:0])),
            .i_c3    ($signed(r_cfg[2*r+1][63:32])),
            .o_valid (sum_valid[r]),
            .o_sum   (row_sum[r])
        );
    end

    // Each of the first three sums is divided by w, the fourth sum. All lanes run in
    // lockstep, so the valid and fault flags of the x lane stand for the whole word.
    logic                    div_valid;
    logic                    div_fault;
    logic [ppt_pkg::Q_W-1:0] quot_x, quot_y, quot_z;

    ppt_div #(
        .FRAC_BITS (FRAC_BITS)
    ) u_div_x (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (sum_valid[0] && sum_valid[3]),
        .i_num   (row_sum[0]),
        .i_den   (row_sum[3]),
        .o_valid (div_valid),
        .o_quot  (quot_x),
        .o_fault (div_fault)
    );

    ppt_div #(
        .FRAC_BITS (FRAC_BITS)
    ) u_div_y (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (sum_valid[1]),
        .i_num   (row_sum[1]),
        .i_den   (row_sum[3]),
        .o_valid (),
        .o_quot  (quot_y),
        .o_fault ()
    );

    ppt_div #(
        .FRAC_BITS (FRAC_BITS)
    ) u_div_z (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (sum_valid[2]),
        .i_num   (row_sum[2]),
        .i_den   (row_sum[3]),
        .o_valid (),
        .o_quot  (quot_z),
        .o_fault ()
    );

    // Divider outputs are registered, so they drive the result ports directly.
    assign o_done         = div_valid;
    assign o_out_x        = $signed(quot_x);
    assign o_out_y        = $signed(quot_y);
    assign o_out_z        = $signed(quot_z);
    assign o_w_zero_fault = div_fault;

endmodule

// File: src/ppt_row_mac.sv
// One matrix row: three products and the offset summed exactly over three stages.
module ppt_row_mac #(
    parameter int FRAC_BITS = 16
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_valid,
    input  ppt_pkg::t_coef i_x,
    input  ppt_pkg::t_coef i_y,
    input  ppt_pkg::t_coef i_z,
    input  ppt_pkg::t_coef i_c0,
    input  ppt_pkg::t_coef i_c1,
    input  ppt_pkg::t_coef i_c2,
    input  ppt_pkg::t_coef i_c3,
    output logic           o_valid,
    output ppt_pkg::t_sum  o_sum
);

    localparam int PROD_W = 2 * ppt_pkg::COEF_W;

    logic [2:0] r_valid;

    logic signed [PROD_W-1:0] r_p0, r_p1, r_p2;
    logic signed [PROD_W-1:0] n_p0, n_p1, n_p2;
    ppt_pkg::t_sum r_off, n_off;
    ppt_pkg::t_sum r_a, r_b, n_a, n_b;
    ppt_pkg::t_sum r_s, n_s;

    always_comb begin
        n_p0  = PROD_W'(i_c0) * PROD_W'(i_x);
        n_p1  = PROD_W'(i_c1) * PROD_W'(i_y);
        n_p2  = PROD_W'(i_c2) * PROD_W'(i_z);
        n_off = ppt_pkg::t_sum'(i_c3) <<< FRAC_BITS;
        n_a   = ppt_pkg::t_sum'(r_p0) + ppt_pkg::t_sum'(r_p1);
        n_b   = ppt_pkg::t_sum'(r_p2) + r_off;
        n_s   = r_a + r_b;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
        end else begin
            r_valid <= {r_valid[1:0], i_valid};
        end
    end

    always_ff @(posedge i_clk) begin
        r_p0  <= n_p0;
        r_p1  <= n_p1;
        r_p2  <= n_p2;
        r_off <= n_off;
        r_a   <= n_a;
        r_b   <= n_b;
        r_s   <= n_s;
    end

    assign o_valid = r_valid[2];
    assign o_sum   = r_s;

endmodule

// File: src/ppt_div_step.sv
// One restoring division step: trial subtract of the divisor shifted by SHIFT.
module ppt_div_step #(
    parameter int SHIFT = 0
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  ppt_pkg::t_div_lane i_lane,
    output ppt_pkg::t_div_lane o_lane
);

    ppt_pkg::t_div_lane r_lane, n_lane;
    logic [ppt_pkg::DIV_W-1:0] trial;

    always_comb begin
        trial  = ppt_pkg::DIV_W'(i_lane.m) << SHIFT;
        n_lane = i_lane;
        if (i_lane.rem >= trial) begin
            n_lane.rem      = i_lane.rem - trial;
            n_lane.q[SHIFT] = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_lane <= '0;
        end else begin
            r_lane <= n_lane;
        end
    end

    assign o_lane = r_lane;

endmodule

// File: src/ppt_div.sv
// Pipelined signed fixed-point divider with saturation and zero-divisor handling.
module ppt_div #(
    parameter int FRAC_BITS = 16
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_valid,
    input  ppt_pkg::t_sum            i_num,
    input  ppt_pkg::t_sum            i_den,
    output logic                     o_valid,
    output logic [ppt_pkg::Q_W-1:0]  o_quot,
    output logic                     o_fault
);

    localparam int QW = ppt_pkg::Q_W;

    // Sign and magnitude stage.
    logic                      r_v1;
    logic [ppt_pkg::MAG_W-1:0] r_n_mag, r_d_mag, n_n_mag, n_d_mag;
    logic                      r_n_neg, r_d_neg, r_n_zero, r_d_zero;

    // Range check stage feeds the step chain.
    ppt_pkg::t_div_lane r_lane0, n_lane0;
    ppt_pkg::t_div_lane lanes [QW+1];

    logic            r_out_valid;
    logic [QW-1:0]   r_quot, n_quot;
    logic            r_fault;

    always_comb begin
        n_n_mag = i_num[ppt_pkg::SUM_W-1] ? ppt_pkg::MAG_W'(-i_num) : ppt_pkg::MAG_W'(i_num);
        n_d_mag = i_den[ppt_pkg::SUM_W-1] ? ppt_pkg::MAG_W'(-i_den) : ppt_pkg::MAG_W'(i_den);
    end

    always_comb begin
        n_lane0.valid  = r_v1;
        n_lane0.rem    = ppt_pkg::DIV_W'(r_n_mag) << FRAC_BITS;
        n_lane0.m      = r_d_mag;
        n_lane0.q      = '0;
        n_lane0.neg    = r_n_neg ^ r_d_neg;
        n_lane0.n_neg  = r_n_neg;
        n_lane0.n_zero = r_n_zero;
        n_lane0.d_zero = r_d_zero;
        // The quotient does not fit in 32 bits when the dividend reaches the divisor times 2^32.
        n_lane0.sat    = n_lane0.rem >= {r_d_mag, {QW{1'b0}}};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1    <= 1'b0;
            r_lane0 <= '0;
        end else begin
            r_v1    <= i_valid;
            r_lane0 <= n_lane0;
        end
    end

    always_ff @(posedge i_clk) begin
        r_n_mag        <= n_n_mag;
        r_d_mag        <= n_d_mag;
        r_n_neg        <= i_num[ppt_pkg::SUM_W-1];
        r_d_neg        <= i_den[ppt_pkg::SUM_W-1];
        r_n_zero       <= (i_num == '0);
        r_d_zero       <= (i_den == '0);
    end

    assign lanes[0] = r_lane0;

    // Most significant quotient bit first.
    for (genvar k = 0; k < QW; k++) begin : g_step
        ppt_div_step #(
            .SHIFT (QW - 1 - k)
        ) u_step (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_lane  (lanes[k]),
            .o_lane  (lanes[k+1])
        );
    end

    always_comb begin
        if (lanes[QW].d_zero) begin
            if (lanes[QW].n_zero) begin
                n_quot = '0;
            end else if (lanes[QW].n_neg) begin
                n_quot = ppt_pkg::S32_MIN;
            end else begin
                n_quot = ppt_pkg::S32_MAX;
            end
        end else if (lanes[QW].sat) begin
            n_quot = lanes[QW].neg ? ppt_pkg::S32_MIN : ppt_pkg::S32_MAX;
        end else if (lanes[QW].neg) begin
            n_quot = (lanes[QW].q > ppt_pkg::S32_MIN) ? ppt_pkg::S32_MIN : -lanes[QW].q;
        end else begin
            n_quot = (lanes[QW].q > ppt_pkg::S32_MAX) ? ppt_pkg::S32_MAX : lanes[QW].q;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else begin
            r_out_valid <= lanes[QW].valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_quot  <= n_quot;
        r_fault <= lanes[QW].d_zero;
    end

    assign o_valid = r_out_valid;
    assign o_quot  = r_quot;
    assign o_fault = r_fault;

endmodule
